>>> rtl/ttd_pkg.sv
package ttd_pkg;

  localparam int TIME_BITS = 40;
  localparam int COORD_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CNT_W     = 4;

  localparam int READY_BIT  = 7;
  localparam int MAX_POINTS = 5;
  localparam int US_PER_MS  = 1000;

  // Largest limit is 65535 * 1000 + 999, which needs 26 bits.
  localparam int LIMIT_W = 26;

  localparam logic [CFG_W-1:0] DUR_RST   = CFG_W'(300);
  localparam logic [CFG_W-1:0] MOVE_RST  = CFG_W'(30);
  localparam logic [CFG_W-1:0] WIDTH_RST = CFG_W'(540);

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_DUR   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_MOVE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SCR_WIDTH = 2'd2;

  typedef enum logic [1:0] {
    TAP_NONE = 2'd0,
    TAP_BACK = 2'd1,
    TAP_FWD  = 2'd2
  } tap_t;

  typedef struct packed {
    logic [7:0]           status_byte;
    logic                 point_read_ok;
    logic [COORD_W-1:0]   point_x;
    logic [COORD_W-1:0]   point_y;
    logic [TIME_BITS-1:0] now_us;
  } poll_t;

  typedef struct packed {
    tap_t tap_event;
    logic clear_status;
    logic is_touching;
  } result_t;

  // Duration limit kept in microseconds: elapsed / 1000 <= d holds exactly
  // when elapsed <= d * 1000 + 999.
  typedef struct packed {
    logic [LIMIT_W-1:0] dur_limit_us;
    logic [CFG_W-1:0]   max_move;
    logic [CFG_W-1:0]   half_width;
  } cfg_t;

  function automatic logic [LIMIT_W-1:0] dur_limit(input logic [CFG_W-1:0] ms);
    dur_limit = LIMIT_W'(ms) * LIMIT_W'(US_PER_MS) + LIMIT_W'(US_PER_MS - 1);
  endfunction

endpackage

>>> rtl/ttd_poll_if.sv
interface ttd_poll_if;
  logic                           valid;
  logic                           ready;
  logic [7:0]                     status_byte;
  logic                           point_read_ok;
  logic [ttd_pkg::COORD_W-1:0]    point_x;
  logic [ttd_pkg::COORD_W-1:0]    point_y;
  logic [ttd_pkg::TIME_BITS-1:0]  now_us;

  modport source (
    output valid, status_byte, point_read_ok, point_x, point_y, now_us,
    input  ready
  );
  modport sink (
    input  valid, status_byte, point_read_ok, point_x, point_y, now_us,
    output ready
  );
endinterface

>>> rtl/ttd_report_if.sv
interface ttd_report_if;
  logic       valid;
  logic       ready;
  logic [1:0] tap_event;
  logic       clear_status;
  logic       is_touching;

  modport source (
    output valid, tap_event, clear_status, is_touching,
    input  ready
  );
  modport sink (
    input  valid, tap_event, clear_status, is_touching,
    output ready
  );
endinterface

>>> rtl/ttd_cfg.sv
module ttd_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [ttd_pkg::REG_IDX_W-1:0]    index,
  input  logic [ttd_pkg::CFG_W-1:0]        data,
  output ttd_pkg::cfg_t                    cfg
);

  ttd_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.dur_limit_us <= ttd_pkg::dur_limit(ttd_pkg::DUR_RST);
      regs.max_move     <= ttd_pkg::MOVE_RST;
      regs.half_width   <= ttd_pkg::WIDTH_RST >> 1;
    end else if (wr_en) begin
      case (index)
        ttd_pkg::REG_MAX_DUR:   regs.dur_limit_us <= ttd_pkg::dur_limit(data);
        ttd_pkg::REG_MAX_MOVE:  regs.max_move     <= data;
        ttd_pkg::REG_SCR_WIDTH: regs.half_width   <= data >> 1;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

>>> rtl/ttd_core.sv
module ttd_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  ttd_pkg::poll_t   poll,
  input  ttd_pkg::cfg_t    cfg,
  output ttd_pkg::result_t result
);

  logic                             touch_active;
  logic [ttd_pkg::COORD_W-1:0]      start_x;
  logic [ttd_pkg::COORD_W-1:0]      start_y;
  logic [ttd_pkg::TIME_BITS-1:0]    start_time;
  logic [ttd_pkg::COORD_W-1:0]      latest_x;
  logic [ttd_pkg::COORD_W-1:0]      latest_y;

  logic                             data_ready;
  logic [ttd_pkg::CNT_W-1:0]        count;
  logic                             has_points;
  logic                             do_update;
  logic                             do_start;
  logic                             do_end;
  logic [ttd_pkg::TIME_BITS-1:0]    elapsed;
  logic [ttd_pkg::COORD_W-1:0]      dx;
  logic [ttd_pkg::COORD_W-1:0]      dy;
  logic                             is_tap;
  logic                             touch_active_next;

  always_comb begin
    data_ready = poll.status_byte[ttd_pkg::READY_BIT];
    count      = poll.status_byte[ttd_pkg::CNT_W-1:0];
    has_points = (count != '0) && (count <= ttd_pkg::CNT_W'(ttd_pkg::MAX_POINTS));
    do_update  = data_ready && has_points && poll.point_read_ok;
    do_start   = do_update && !touch_active;
    do_end     = data_ready && (count == '0) && touch_active;

    // The subtraction wraps at the timestamp width, as the counter does.
    elapsed = poll.now_us - start_time;
    dx = (latest_x >= start_x) ? latest_x - start_x : start_x - latest_x;
    dy = (latest_y >= start_y) ? latest_y - start_y : start_y - latest_y;
    is_tap = (elapsed <= ttd_pkg::TIME_BITS'(cfg.dur_limit_us))
          && (dx <= cfg.max_move) && (dy <= cfg.max_move);

    if (do_end) begin
      touch_active_next = 1'b0;
    end else if (do_start) begin
      touch_active_next = 1'b1;
    end else begin
      touch_active_next = touch_active;
    end

    result.tap_event = ttd_pkg::TAP_NONE;
    if (do_end && is_tap) begin
      result.tap_event = (latest_x < cfg.half_width) ? ttd_pkg::TAP_BACK : ttd_pkg::TAP_FWD;
    end
    result.clear_status = data_ready;
    result.is_touching  = touch_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_active <= 1'b0;
    end else if (adv) begin
      touch_active <= touch_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && do_start) begin
      start_x    <= poll.point_x;
      start_y    <= poll.point_y;
      start_time <= poll.now_us;
    end
    if (adv && do_update) begin
      latest_x <= poll.point_x;
      latest_y <= poll.point_y;
    end
  end

endmodule

>>> rtl/touch_tap_detector.sv
// Tap gesture detector for a touch controller that is polled.
//
// Each beat on the poll channel is one controller poll: status byte, read
// flag of the first point, its x and y, and a 40-bit microsecond timestamp.
// Each poll yields exactly one beat on the report channel: tap event
// (none, back, forward), the status-clear request and the touch flag.
//
// A poll is captured in an input register at the accepting edge; it runs
// through the tracker into the report register once that register is empty
// or its beat is being taken. One poll is taken per cycle
// when the report side is not stalled. When the receiver holds ready low,
// the report register keeps its beat, one more poll waits in the input
// register, and poll.ready falls until the report is taken.
//
// Reset clears the touch flag, both valid bits and loads the default limits
// (300 ms, 30 units, width 540). The user must write the limit registers
// via cfg_wr_en, cfg_index, cfg_data while no poll is in flight (unenforced).
module touch_tap_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [ttd_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [ttd_pkg::CFG_W-1:0]     cfg_data,
  ttd_poll_if.sink                      poll,
  ttd_report_if.source                  report
);

  ttd_pkg::cfg_t    cfg;
  ttd_pkg::poll_t   poll_r;
  logic             poll_vld;
  ttd_pkg::result_t res_next;
  ttd_pkg::result_t res_r;
  logic             out_vld;
  logic             adv;

  assign adv        = poll_vld && (!out_vld || report.ready);
  assign poll.ready = !poll_vld || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_vld <= 1'b0;
    end else if (poll.ready) begin
      poll_vld <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      poll_r.status_byte   <= poll.status_byte;
      poll_r.point_read_ok <= poll.point_read_ok;
      poll_r.point_x       <= poll.point_x;
      poll_r.point_y       <= poll.point_y;
      poll_r.now_us        <= poll.now_us;
    end
  end

  ttd_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  ttd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .poll   (poll_r),
    .cfg    (cfg),
    .result (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= 1'b1;
    end else if (report.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_next;
    end
  end

  assign report.valid        = out_vld;
  assign report.tap_event    = 2'(res_r.tap_event);
  assign report.clear_status = res_r.clear_status;
  assign report.is_touching  = res_r.is_touching;

  // A poll that leaves the input register always lands in the report register.
  a_adv_loads: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_vld)
    else $error("advanced poll did not produce a report");

  // A tap only comes from a ready poll that ended the touch.
  a_tap_ends: assert property (@(posedge clk) disable iff (rst)
    (out_vld && res_r.tap_event != ttd_pkg::TAP_NONE)
      |-> (res_r.clear_status && !res_r.is_touching))
    else $error("tap reported without a touch release");

  // A poll without the ready bit never reports a tap.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !res_r.clear_status) |-> (res_r.tap_event == ttd_pkg::TAP_NONE))
    else $error("tap reported on a poll that was not ready");

endmodule

>>> verif/touch_tap_detector_tb.sv
module touch_tap_detector_tb;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_RUNS,
    RX_SLOW
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [ttd_pkg::REG_IDX_W-1:0] cfg_index;
  logic [ttd_pkg::CFG_W-1:0] cfg_data;

  ttd_poll_if poll_ch ();
  ttd_report_if report_ch ();

  touch_tap_detector dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .poll      (poll_ch),
    .report    (report_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Limits as the block should hold them.
  logic [ttd_pkg::CFG_W-1:0] lim_dur_ms = ttd_pkg::DUR_RST;
  logic [ttd_pkg::CFG_W-1:0] lim_move   = ttd_pkg::MOVE_RST;
  logic [ttd_pkg::CFG_W-1:0] lim_width  = ttd_pkg::WIDTH_RST;

  // Touch tracking state mirrored from the block.
  logic                          touching = 1'b0;
  logic [ttd_pkg::COORD_W-1:0]   down_x = '0;
  logic [ttd_pkg::COORD_W-1:0]   down_y = '0;
  logic [ttd_pkg::TIME_BITS-1:0] down_us = '0;
  logic [ttd_pkg::COORD_W-1:0]   last_x = '0;
  logic [ttd_pkg::COORD_W-1:0]   last_y = '0;

  ttd_pkg::poll_t   pending_polls[$];
  ttd_pkg::result_t expected_reports[$];
  int               polls_queued = 0;
  int               mismatches = 0;

  int               burst_left = 0;
  int               gap_left = 0;
  rx_mode_t         rx_mode = RX_FREE;
  int               rx_mode_left = 0;
  int               rx_stall_left = 0;
  logic             rx_take;
  ttd_pkg::result_t want;

  function automatic logic [ttd_pkg::COORD_W-1:0] span(
      input logic [ttd_pkg::COORD_W-1:0] a,
      input logic [ttd_pkg::COORD_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Runs one poll through the tracker and returns the report it yields.
  function automatic ttd_pkg::result_t track_poll(input ttd_pkg::poll_t p);
    ttd_pkg::result_t r;
    logic [ttd_pkg::CNT_W-1:0] npts;
    logic [ttd_pkg::TIME_BITS-1:0] held_ms;
    r.tap_event = ttd_pkg::TAP_NONE;
    r.clear_status = 1'b0;
    if (p.status_byte[ttd_pkg::READY_BIT]) begin
      npts = p.status_byte[ttd_pkg::CNT_W-1:0];
      if (npts != 0 && npts <= ttd_pkg::MAX_POINTS) begin
        if (p.point_read_ok) begin
          if (!touching) begin
            touching = 1'b1;
            down_x = p.point_x;
            down_y = p.point_y;
            down_us = p.now_us;
          end
          last_x = p.point_x;
          last_y = p.point_y;
        end
      end else if (npts == 0 && touching) begin
        // The subtraction wraps at the timestamp width, like the counter.
        held_ms = ttd_pkg::TIME_BITS'(p.now_us - down_us) / ttd_pkg::US_PER_MS;
        if (held_ms <= lim_dur_ms && span(last_x, down_x) <= lim_move &&
            span(last_y, down_y) <= lim_move) begin
          r.tap_event = (last_x < (lim_width >> 1)) ? ttd_pkg::TAP_BACK : ttd_pkg::TAP_FWD;
        end
        touching = 1'b0;
      end
      r.clear_status = 1'b1;
    end
    r.is_touching = touching;
    return r;
  endfunction

  task automatic add_poll(input logic [7:0] status, input logic ok,
                          input logic [ttd_pkg::COORD_W-1:0] x,
                          input logic [ttd_pkg::COORD_W-1:0] y,
                          input logic [ttd_pkg::TIME_BITS-1:0] t);
    ttd_pkg::poll_t p;
    p.status_byte = status;
    p.point_read_ok = ok;
    p.point_x = x;
    p.point_y = y;
    p.now_us = t;
    pending_polls.push_back(p);
    polls_queued++;
  endtask

  function automatic logic [ttd_pkg::TIME_BITS-1:0] any_time();
    return ttd_pkg::TIME_BITS'({$urandom, $urandom});
  endfunction

  // Data-ready status with the given point count and random unused bits.
  function automatic logic [7:0] ready_status(input int npts);
    return {1'b1, 3'($urandom), 4'(npts)};
  endfunction

  // Moves a coordinate by an amount picked around the movement limit, or replaces it with a random value.
  function automatic logic [ttd_pkg::COORD_W-1:0] nudge(
      input logic [ttd_pkg::COORD_W-1:0] base);
    int m;
    int d;
    m = lim_move;
    case ($urandom_range(0, 6))
      0: d = 0;
      1: d = m;
      2: d = -m;
      3: d = m + 1;
      4: d = -(m + 1);
      5: d = $urandom_range(0, 1) ? int'($urandom_range(0, m)) : -int'($urandom_range(0, m));
      default: return ttd_pkg::COORD_W'($urandom);
    endcase
    return ttd_pkg::COORD_W'(int'(base) + d);
  endfunction

  // One press, a few moves mixed with polls that must not disturb it, and a
  // release timed around the duration limit.
  task automatic queue_gesture();
    logic [ttd_pkg::COORD_W-1:0] sx;
    logic [ttd_pkg::COORD_W-1:0] sy;
    logic [ttd_pkg::COORD_W-1:0] half_w;
    logic [ttd_pkg::TIME_BITS-1:0] t0;
    longint dt;
    longint lim_us;
    half_w = lim_width >> 1;
    lim_us = longint'(lim_dur_ms) * 1000;
    // Some presses start just below the timestamp wrap.
    t0 = ($urandom_range(0, 3) == 0)
         ? ttd_pkg::TIME_BITS'(0) - ttd_pkg::TIME_BITS'($urandom_range(1, 2000000))
         : any_time();
    case ($urandom_range(0, 3))
      0: sx = ttd_pkg::COORD_W'($urandom);
      1: sx = half_w + ttd_pkg::COORD_W'($urandom_range(0, 2)) - 1'b1;
      2: sx = '0;
      default: sx = '1;
    endcase
    sy = ttd_pkg::COORD_W'($urandom);
    add_poll(ready_status($urandom_range(1, ttd_pkg::MAX_POINTS)), 1'b1, sx, sy, t0);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 7))
        0: add_poll({1'b0, 7'($urandom)}, 1'($urandom), ttd_pkg::COORD_W'($urandom),
                    ttd_pkg::COORD_W'($urandom), any_time());
        1: add_poll(ready_status($urandom_range(1, ttd_pkg::MAX_POINTS)), 1'b0,
                    ttd_pkg::COORD_W'($urandom), ttd_pkg::COORD_W'($urandom), any_time());
        2: add_poll(ready_status($urandom_range(ttd_pkg::MAX_POINTS + 1, 15)), 1'($urandom),
                    ttd_pkg::COORD_W'($urandom), ttd_pkg::COORD_W'($urandom), any_time());
        default: add_poll(ready_status($urandom_range(1, ttd_pkg::MAX_POINTS)), 1'b1,
                          nudge(sx), nudge(sy),
                          t0 + ttd_pkg::TIME_BITS'($urandom_range(0, 100000)));
      endcase
    end
    case ($urandom_range(0, 5))
      0: dt = $urandom_range(0, 999);
      1: dt = lim_us + 999;
      2: dt = lim_us + 1000;
      3: dt = $urandom_range(0, 32'(lim_us + 999));
      4: dt = longint'(any_time());
      default: dt = lim_us - $urandom_range(0, 2000);
    endcase
    add_poll(ready_status(0), 1'($urandom), ttd_pkg::COORD_W'($urandom),
             ttd_pkg::COORD_W'($urandom), t0 + ttd_pkg::TIME_BITS'(dt));
  endtask

  task automatic queue_random(input int n);
    int target;
    target = polls_queued + n;
    while (polls_queued < target) begin
      if ($urandom_range(0, 4) != 0) queue_gesture();
      else add_poll(8'($urandom), 1'($urandom), ttd_pkg::COORD_W'($urandom),
                    ttd_pkg::COORD_W'($urandom), any_time());
    end
  endtask

  // Holds off until every poll is taken and every report has come back.
  task automatic settle();
    while (pending_polls.size() != 0 || expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ttd_pkg::REG_IDX_W-1:0] idx,
                           input logic [ttd_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      ttd_pkg::REG_MAX_DUR:   lim_dur_ms = val;
      ttd_pkg::REG_MAX_MOVE:  lim_move = val;
      ttd_pkg::REG_SCR_WIDTH: lim_width = val;
      default: ;
    endcase
  endtask

  task automatic apply_limits(input logic [ttd_pkg::CFG_W-1:0] dur,
                              input logic [ttd_pkg::CFG_W-1:0] move,
                              input logic [ttd_pkg::CFG_W-1:0] width);
    write_reg(ttd_pkg::REG_MAX_DUR, dur);
    write_reg(ttd_pkg::REG_MAX_MOVE, move);
    write_reg(ttd_pkg::REG_SCR_WIDTH, width);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Poll sender: bursts of random length separated by random gaps. A beat
  // that is offered stays up until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      poll_ch.valid <= 1'b0;
      poll_ch.status_byte <= '0;
      poll_ch.point_read_ok <= 1'b0;
      poll_ch.point_x <= '0;
      poll_ch.point_y <= '0;
      poll_ch.now_us <= '0;
    end else begin
      if (poll_ch.valid && poll_ch.ready) begin
        expected_reports.push_back(track_poll(pending_polls.pop_front()));
      end
      if (!(poll_ch.valid && !poll_ch.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          poll_ch.valid <= 1'b0;
        end else if (pending_polls.size() != 0) begin
          poll_ch.valid <= 1'b1;
          poll_ch.status_byte <= pending_polls[0].status_byte;
          poll_ch.point_read_ok <= pending_polls[0].point_read_ok;
          poll_ch.point_x <= pending_polls[0].point_x;
          poll_ch.point_y <= pending_polls[0].point_y;
          poll_ch.now_us <= pending_polls[0].now_us;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          poll_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Report receiver and checker.
  always @(posedge clk) begin
    if (rst) begin
      report_ch.ready <= 1'b0;
    end else begin
      if (report_ch.valid && report_ch.ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report beat with none expected: tap %0d clear %0d touching %0d",
                     report_ch.tap_event, report_ch.clear_status, report_ch.is_touching);
        end else begin
          want = expected_reports.pop_front();
          if (report_ch.tap_event !== want.tap_event ||
              report_ch.clear_status !== want.clear_status ||
              report_ch.is_touching !== want.is_touching) begin
            mismatches++;
            if (mismatches <= 10)
              $display("report mismatch: expected tap %0d clear %0d touching %0d, got %0d %0d %0d",
                       want.tap_event, want.clear_status, want.is_touching,
                       report_ch.tap_event, report_ch.clear_status, report_ch.is_touching);
          end
        end
      end
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 200);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_FREE: rx_take = 1'b1;
        RX_COIN: rx_take = 1'($urandom_range(0, 1));
        RX_RUNS: begin
          if (rx_stall_left > 0) begin
            rx_stall_left--;
            rx_take = 1'b0;
          end else begin
            rx_take = 1'b1;
            if ($urandom_range(0, 3) == 0) rx_stall_left = $urandom_range(1, 15);
          end
        end
        default: rx_take = ($urandom_range(0, 3) == 0);
      endcase
      report_ch.ready <= rx_take;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = ttd_pkg::REG_MAX_DUR;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Default limits: 300 ms, 30 units, half width 270.
    add_poll(8'h7F, 1'b1, 16'hFFFF, 16'hFFFF, '1);
    add_poll(8'h80, 1'b0, 16'h0000, 16'h0000, '0);
    add_poll(8'h86, 1'b1, 16'd1234, 16'd1234, 40'd50);
    add_poll(8'h8F, 1'b1, 16'd1234, 16'd1234, 40'd60);
    add_poll(8'h81, 1'b0, 16'd1234, 16'd1234, 40'd70);
    add_poll(8'hF5, 1'b1, 16'd100, 16'd200, 40'd1000);
    add_poll(8'h82, 1'b1, 16'd130, 16'd170, 40'd1100);
    add_poll(8'h05, 1'b1, 16'd9999, 16'd9999, 40'd1200);
    add_poll(8'h83, 1'b0, 16'd5000, 16'd5000, 40'd1300);
    add_poll(8'h8A, 1'b1, 16'd5000, 16'd5000, 40'd1400);
    add_poll(8'h80, 1'b1, 16'd7, 16'd7, 40'd301999);
    // Touch that straddles the timestamp wrap, released at the last microsecond that still counts as 300 ms.
    add_poll(8'h81, 1'b1, 16'd270, 16'd0, 40'hFF_FFFF_FE0C);
    add_poll(8'h80, 1'b0, 16'd0, 16'd0, 40'hFF_FFFF_FE0C + 40'd300999);
    add_poll(8'h81, 1'b1, 16'd269, 16'hFFFF, 40'h10);
    add_poll(8'h80, 1'b1, 16'd0, 16'd0, 40'h10 + 40'd301000);
    add_poll(8'h84, 1'b1, 16'd0, 16'd0, 40'd5);
    add_poll(8'h84, 1'b1, 16'd31, 16'd0, 40'd6);
    add_poll(8'h80, 1'b1, 16'd0, 16'd0, 40'd7);
    add_poll(8'h81, 1'b1, 16'hFFFF, 16'hFFFF, '1);
    add_poll(8'h80, 1'b1, 16'd0, 16'd0, '1);
    settle();

    queue_random(100);
    settle();
    queue_random(100);
    settle();

    apply_limits(16'd0, 16'd0, 16'd1);
    queue_random(140);
    settle();

    apply_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random(140);
    settle();

    // With a zero width every tap lands in the forward half.
    apply_limits(16'd5, 16'd3, 16'd0);
    add_poll(8'h81, 1'b1, 16'd0, 16'd0, 40'd100);
    add_poll(8'h80, 1'b1, 16'd0, 16'd0, 40'd200);
    queue_random(100);
    settle();

    repeat (3) begin
      apply_limits(($urandom_range(0, 3) == 0) ? ttd_pkg::CFG_W'($urandom)
                                               : ttd_pkg::CFG_W'($urandom_range(0, 1000)),
                   ($urandom_range(0, 3) == 0) ? ttd_pkg::CFG_W'($urandom)
                                               : ttd_pkg::CFG_W'($urandom_range(0, 100)),
                   ttd_pkg::CFG_W'($urandom_range(1, 65535)));
      queue_random(130);
      settle();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/ttd_pkg.sv
rtl/ttd_poll_if.sv
rtl/ttd_report_if.sv
rtl/ttd_cfg.sv
rtl/ttd_core.sv
rtl/touch_tap_detector.sv
verif/touch_tap_detector_tb.sv
